// ===== rtl/sfpm_pkg.sv =====
// Shared types, widths and helper functions of the scan field pixel/mm mapper.
package sfpm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;
  localparam int DIM_W     = 14;
  localparam int CMD_W     = 2;
  localparam int MODE_W    = 2;

  // Datapath widths, all derived from the coordinate width and FRAC_BITS
  localparam int DX_W  = CW + 1;
  localparam int PX_W  = DX_W + CW;
  localparam int XP_W  = PX_W - FRAC_BITS;
  localparam int PR_W  = 2 * CW;
  localparam int YW_W  = XP_W + 1;
  localparam int DVD_W = CW + FRAC_BITS;
  localparam int Q_W   = DVD_W + 1;
  localparam int MIR_A = YW_W + 2;
  localparam int DIV_A = Q_W + 1;
  localparam int SAT_W = (MIR_A > DIV_A) ? MIR_A : DIV_A;

  localparam int IN_DATA_W  = ((2 * CW + 2 * DIM_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = 2 * CW;

  typedef logic signed [SAT_W-1:0] wide_t;
  typedef logic signed [CW-1:0]    coord_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TO_PIXEL = 2'd0,
    CMD_TO_MM    = 2'd1,
    CMD_CORNER   = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_X_ORIGIN = 3'd0,
    REG_Y_ORIGIN = 3'd1,
    REG_X_SCALE  = 3'd2,
    REG_Y_SCALE  = 3'd3,
    REG_SLOPE    = 3'd4,
    REG_WIDTH    = 3'd5,
    REG_HEIGHT   = 3'd6,
    REG_FILL     = 3'd7
  } reg_e;

  typedef struct packed {
    coord_t val;
    logic   sat;
  } sat_t;

  // Side information that rides along the divider
  typedef struct packed {
    cmd_e       cmd;
    coord_t     rx;
    coord_t     ry;
    logic       sat;
    logic       zero;
    logic [1:0] neg;
    logic [1:0] dz;
  } side_t;

  function automatic sat_t sat32(input wide_t v);
    sat_t  r;
    wide_t maxv;
    wide_t minv;
    maxv = {{(SAT_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    minv = {{(SAT_W-CW+1){1'b1}}, {(CW-1){1'b0}}};
    r.sat = 1'b1;
    if (v > maxv) begin
      r.val = maxv[CW-1:0];
    end else if (v < minv) begin
      r.val = minv[CW-1:0];
    end else begin
      r.val = v[CW-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // Last pixel position of an axis: (dim - 1) in Q format
  function automatic wide_t img_edge(input logic [DIM_W-1:0] d);
    wide_t e;
    e = wide_t'(d) <<< FRAC_BITS;
    return e - (wide_t'(1) <<< FRAC_BITS);
  endfunction

  // Clear the fraction, rounding toward zero
  function automatic wide_t trunc_q(input wide_t v);
    wide_t fl;
    fl = v >>> FRAC_BITS;
    if (v[SAT_W-1] && (v[FRAC_BITS-1:0] != '0)) begin
      fl = fl + wide_t'(1);
    end
    return fl <<< FRAC_BITS;
  endfunction

  function automatic logic [CW-1:0] abs_u(input coord_t c);
    return c[CW-1] ? (~c + CW'(1)) : c;
  endfunction

endpackage

// ===== rtl/sfpm_div.sv =====
// Pipelined restoring divider, two lanes, one quotient bit per stage.
module sfpm_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [1:0][sfpm_pkg::DVD_W-1:0]      dvd_i,
  input  logic [1:0][sfpm_pkg::CW-1:0]         den_i,
  input  sfpm_pkg::side_t                      side_i,
  output logic                                 valid_o,
  output logic [1:0][sfpm_pkg::DVD_W-1:0]      quo_o,
  output sfpm_pkg::side_t                      side_o
);
  import sfpm_pkg::*;

  localparam int N = DVD_W;

  logic [N:0]                  v_q;
  logic [1:0][DVD_W-1:0]       acc_q  [N+1];
  logic [1:0][CW-1:0]          rem_q  [N];
  logic [1:0][CW-1:0]          den_q  [N];
  side_t                       side_q [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q[0]  <= dvd_i;
      rem_q[0]  <= '0;
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [CW:0]    rs;
      logic [CW:0]    diff;
      logic           ge;
      logic [CW-1:0]  rem_d;
      logic [DVD_W-1:0] acc_d;

      always_comb begin
        rs    = {rem_q[k][l], acc_q[k][l][DVD_W-1]};
        diff  = rs - {1'b0, den_q[k][l]};
        ge    = (rs >= {1'b0, den_q[k][l]});
        rem_d = ge ? diff[CW-1:0] : rs[CW-1:0];
        acc_d = {acc_q[k][l][DVD_W-2:0], ge};
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          acc_q[k+1][l] <= acc_d;
        end
      end

      if (k < N - 1) begin : g_carry
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rem_q[k+1][l] <= rem_d;
            den_q[k+1][l] <= den_q[k][l];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = v_q[N];
  assign quo_o   = acc_q[N];
  assign side_o  = side_q[N];

endmodule

// ===== rtl/scan_field_pixel_mm_mapper.sv =====
// Top level of the scan field pixel/mm mapper: config registers and pipelined datapath.
//
// Converts scanner positions in mm to pixel positions of a stitched scan field
// image and back, in signed Q16.16, with saturation of every result.
// Input channel (s_axis): tuser carries the command (0 mm to pixel, 1 pixel to
// mm, 2 window top-left corner), tdata the coordinates and the window size.
// Output channel (m_axis): tdata holds out_x and out_y, tuser the flags.
// Configuration channel (cfg_*): one register transfer per cycle, always ready;
// write only while no item is in flight.
// Throughput: one item per cycle while m_axis does not stall. The 48-stage
// restoring divider (one quotient bit per stage) follows the seven multiply
// and mirror stages.
// Every command, including the unused one, yields exactly one result.
// A stall on m_axis holds the entire pipeline in place; s_axis_tready drops
// only while the output register holds a result that is not taken.
// Reset clears all valid bits and loads the register defaults (unit scales,
// zero origins, zero image size, direct fill mode).
module scan_field_pixel_mm_mapper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // first_coord, second_coord, window_width, window_height, zero pad
  input  logic [sfpm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // cmd
  input  logic [sfpm_pkg::CMD_W-1:0]          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_x, out_y
  output logic [sfpm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // scale_zero, saturated
  output logic [1:0]                          m_axis_tuser,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [2:0]                          cfg_index_i,
  input  logic [sfpm_pkg::CW-1:0]             cfg_data_i
);
  import sfpm_pkg::*;

  // ---------------------------------------------------------------- config
  coord_t             xo_q, yo_q, xs_q, ys_q, rs_q;
  logic [DIM_W-1:0]   w_q, h_q;
  logic [MODE_W-1:0]  mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xo_q   <= '0;
      yo_q   <= '0;
      xs_q   <= coord_t'(1) <<< FRAC_BITS;
      ys_q   <= coord_t'(1) <<< FRAC_BITS;
      rs_q   <= '0;
      w_q    <= '0;
      h_q    <= '0;
      mode_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_X_ORIGIN: xo_q   <= cfg_data_i;
        REG_Y_ORIGIN: yo_q   <= cfg_data_i;
        REG_X_SCALE:  xs_q   <= cfg_data_i;
        REG_Y_SCALE:  ys_q   <= cfg_data_i;
        REG_SLOPE:    rs_q   <= cfg_data_i;
        REG_WIDTH:    w_q    <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT:   h_q    <= cfg_data_i[DIM_W-1:0];
        REG_FILL:     mode_q <= cfg_data_i[MODE_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // One enable for the whole pipeline: advance when the output slot frees up
  logic en;
  logic m_valid_q;

  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Unpack the input transfer
  cmd_e             in_cmd;
  coord_t           in_a, in_b;
  logic [DIM_W-1:0] in_ww, in_wh;

  assign in_cmd = cmd_e'(s_axis_tuser);
  assign in_a   = s_axis_tdata[CW-1:0];
  assign in_b   = s_axis_tdata[2*CW-1:CW];
  assign in_ww  = s_axis_tdata[2*CW+DIM_W-1:2*CW];
  assign in_wh  = s_axis_tdata[2*CW+2*DIM_W-1:2*CW+DIM_W];

  // ---------------------------------------------------------------- stage 1
  // Offsets from origin; mirrored pixel input for the inverse
  logic signed [DX_W-1:0] dx_d, dy_d;
  sat_t                   mx_s, my_s;

  always_comb begin
    dx_d = DX_W'(in_a) - DX_W'(xo_q);
    dy_d = DX_W'(in_b) - DX_W'(yo_q);
    mx_s = sat32(mode_q[0] ? img_edge(w_q) - wide_t'(in_a) : wide_t'(in_a));
    my_s = sat32(mode_q[1] ? img_edge(h_q) - wide_t'(in_b) : wide_t'(in_b));
  end

  logic                   v1_q;
  cmd_e                   cmd1_q;
  logic signed [DX_W-1:0] dx1_q, dy1_q;
  coord_t                 mx1_q, my1_q;
  logic                   sat1_q;
  logic [DIM_W-2:0]       hw1_q, hh1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q <= in_cmd;
      dx1_q  <= dx_d;
      dy1_q  <= dy_d;
      mx1_q  <= mx_s.val;
      my1_q  <= my_s.val;
      sat1_q <= (in_cmd == CMD_TO_MM) && (mx_s.sat || my_s.sat);
      hw1_q  <= in_ww[DIM_W-1:1];
      hh1_q  <= in_wh[DIM_W-1:1];
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Scale products and the inverse shear product
  logic                   v2_q;
  cmd_e                   cmd2_q;
  logic signed [PX_W-1:0] px2_q, py2_q;
  logic signed [PR_W-1:0] ps2_q;
  coord_t                 mx2_q, my2_q;
  logic                   sat2_q;
  logic [DIM_W-2:0]       hw2_q, hh2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd2_q <= cmd1_q;
      px2_q  <= dx1_q * xs_q;
      py2_q  <= dy1_q * ys_q;
      ps2_q  <= rs_q * mx1_q;
      mx2_q  <= mx1_q;
      my2_q  <= my1_q;
      sat2_q <= sat1_q;
      hw2_q  <= hw1_q;
      hh2_q  <= hh1_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Drop the fraction; clamp the shear operand and the inverse y numerator
  logic signed [XP_W-1:0] xp_d, yp_d;
  sat_t                   xc_s, ny_s;
  logic                   fwd2;

  always_comb begin
    xp_d = px2_q[PX_W-1:FRAC_BITS];
    yp_d = py2_q[PX_W-1:FRAC_BITS];
    xc_s = sat32(wide_t'(xp_d));
    ny_s = sat32(wide_t'(my2_q) - wide_t'($signed(ps2_q[PR_W-1:FRAC_BITS])));
    fwd2 = (cmd2_q == CMD_TO_PIXEL) || (cmd2_q == CMD_CORNER);
  end

  logic                   v3_q;
  cmd_e                   cmd3_q;
  logic signed [XP_W-1:0] xp3_q, yp3_q;
  coord_t                 xc3_q, mx3_q, ny3_q;
  logic                   sat3_q;
  logic [DIM_W-2:0]       hw3_q, hh3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd3_q <= cmd2_q;
      xp3_q  <= xp_d;
      yp3_q  <= yp_d;
      xc3_q  <= xc_s.val;
      mx3_q  <= mx2_q;
      ny3_q  <= ny_s.val;
      sat3_q <= sat2_q || (fwd2 && xc_s.sat) || ((cmd2_q == CMD_TO_MM) && ny_s.sat);
      hw3_q  <= hw2_q;
      hh3_q  <= hh2_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Forward shear product
  logic                   v4_q;
  cmd_e                   cmd4_q;
  logic signed [PR_W-1:0] pr4_q;
  logic signed [XP_W-1:0] xp4_q, yp4_q;
  coord_t                 mx4_q, ny4_q;
  logic                   sat4_q;
  logic [DIM_W-2:0]       hw4_q, hh4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd4_q <= cmd3_q;
      pr4_q  <= rs_q * xc3_q;
      xp4_q  <= xp3_q;
      yp4_q  <= yp3_q;
      mx4_q  <= mx3_q;
      ny4_q  <= ny3_q;
      sat4_q <= sat3_q;
      hw4_q  <= hw3_q;
      hh4_q  <= hh3_q;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Add the shear to y
  logic                   v5_q;
  cmd_e                   cmd5_q;
  logic signed [XP_W-1:0] xp5_q;
  logic signed [YW_W-1:0] yw5_q;
  coord_t                 mx5_q, ny5_q;
  logic                   sat5_q;
  logic [DIM_W-2:0]       hw5_q, hh5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd5_q <= cmd4_q;
      xp5_q  <= xp4_q;
      yw5_q  <= YW_W'(yp4_q) + YW_W'($signed(pr4_q[PR_W-1:FRAC_BITS]));
      mx5_q  <= mx4_q;
      ny5_q  <= ny4_q;
      sat5_q <= sat4_q;
      hw5_q  <= hw4_q;
      hh5_q  <= hh4_q;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // Mirror for mm to pixel, subtract half a window for the corner
  wide_t ex_d, ey_d;

  always_comb begin
    if (cmd5_q == CMD_CORNER) begin
      ex_d = wide_t'(xp5_q) - (wide_t'(hw5_q) <<< FRAC_BITS);
      ey_d = wide_t'(yw5_q) - (wide_t'(hh5_q) <<< FRAC_BITS);
    end else begin
      ex_d = mode_q[0] ? img_edge(w_q) - wide_t'(xp5_q) : wide_t'(xp5_q);
      ey_d = mode_q[1] ? img_edge(h_q) - wide_t'(yw5_q) : wide_t'(yw5_q);
    end
  end

  logic   v6_q;
  cmd_e   cmd6_q;
  wide_t  ex6_q, ey6_q;
  coord_t mx6_q, ny6_q;
  logic   sat6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd6_q <= cmd5_q;
      ex6_q  <= ex_d;
      ey6_q  <= ey_d;
      mx6_q  <= mx5_q;
      ny6_q  <= ny5_q;
      sat6_q <= sat5_q;
    end
  end

  // ---------------------------------------------------------------- stage 7
  // Final forward results; divider operands for the inverse
  sat_t                  cx_s, cy_s;
  side_t                 side_d;
  logic [1:0][DVD_W-1:0] dvd_d;
  logic [1:0][CW-1:0]    den_d;
  logic                  fwd6;

  always_comb begin
    fwd6 = (cmd6_q == CMD_TO_PIXEL) || (cmd6_q == CMD_CORNER);
    cx_s = sat32((cmd6_q == CMD_CORNER) ? trunc_q(ex6_q) : ex6_q);
    cy_s = sat32((cmd6_q == CMD_CORNER) ? trunc_q(ey6_q) : ey6_q);
    side_d.cmd   = cmd6_q;
    side_d.rx    = cx_s.val;
    side_d.ry    = cy_s.val;
    side_d.sat   = sat6_q || (fwd6 && (cx_s.sat || cy_s.sat));
    side_d.dz    = {ys_q == '0, xs_q == '0};
    side_d.zero  = (cmd6_q == CMD_TO_MM) && (side_d.dz != 2'b00);
    side_d.neg   = {ny6_q[CW-1] ^ ys_q[CW-1], mx6_q[CW-1] ^ xs_q[CW-1]};
    dvd_d[0]     = {abs_u(mx6_q), {FRAC_BITS{1'b0}}};
    dvd_d[1]     = {abs_u(ny6_q), {FRAC_BITS{1'b0}}};
    den_d[0]     = abs_u(xs_q);
    den_d[1]     = abs_u(ys_q);
  end

  logic                  div_valid;
  logic [1:0][DVD_W-1:0] quo;
  side_t                 div_side;

  sfpm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .dvd_i   (dvd_d),
    .den_i   (den_d),
    .side_i  (side_d),
    .valid_o (div_valid),
    .quo_o   (quo),
    .side_o  (div_side)
  );

  // ---------------------------------------------------------------- finish 1
  // Sign the quotients; a zero scale gives a zero quotient
  logic signed [Q_W-1:0] qs_d [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (div_side.dz[l]) begin
        qs_d[l] = '0;
      end else if (div_side.neg[l]) begin
        qs_d[l] = -$signed({1'b0, quo[l]});
      end else begin
        qs_d[l] = $signed({1'b0, quo[l]});
      end
    end
  end

  logic                  f1_v_q;
  side_t                 f1_side_q;
  logic signed [Q_W-1:0] f1_qx_q, f1_qy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_side_q <= div_side;
      f1_qx_q   <= qs_d[0];
      f1_qy_q   <= qs_d[1];
    end
  end

  // ---------------------------------------------------------------- output
  // Add the origins for the inverse and pick the result per command
  sat_t   ox_s, oy_s;
  coord_t out_x_d, out_y_d;
  logic   out_zero_d, out_sat_d;

  always_comb begin
    ox_s = sat32(wide_t'(f1_qx_q) + wide_t'(xo_q));
    oy_s = sat32(wide_t'(f1_qy_q) + wide_t'(yo_q));
    unique case (f1_side_q.cmd)
      CMD_TO_PIXEL, CMD_CORNER: begin
        out_x_d    = f1_side_q.rx;
        out_y_d    = f1_side_q.ry;
        out_zero_d = 1'b0;
        out_sat_d  = f1_side_q.sat;
      end
      CMD_TO_MM: begin
        out_x_d    = ox_s.val;
        out_y_d    = oy_s.val;
        out_zero_d = f1_side_q.zero;
        out_sat_d  = f1_side_q.sat || ox_s.sat || oy_s.sat;
      end
      CMD_UNUSED: begin
        out_x_d    = '0;
        out_y_d    = '0;
        out_zero_d = 1'b0;
        out_sat_d  = 1'b0;
      end
    endcase
  end

  coord_t out_x_q, out_y_q;
  logic   out_zero_q, out_sat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q    <= out_x_d;
      out_y_q    <= out_y_d;
      out_zero_q <= out_zero_d;
      out_sat_q  <= out_sat_d;
    end
  end

  // Valid bits travel with the data and hold during a stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      f1_v_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      v1_q      <= s_axis_tvalid;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= v5_q;
      f1_v_q    <= div_valid;
      m_valid_q <= f1_v_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_y_q, out_x_q};
  assign m_axis_tuser  = {out_sat_q, out_zero_q};

  // ---------------------------------------------------------------- checks
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted transfer did not enter the pipeline");

  a_div_to_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_valid && en |=> f1_v_q)
    else $error("divider result lost");

  a_finish_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    f1_v_q && en |=> m_valid_q)
    else $error("finished result did not reach the output register");

  a_zero_only_inverse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    f1_v_q && f1_side_q.zero |-> f1_side_q.cmd == CMD_TO_MM)
    else $error("zero scale flag on a forward command");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v1_q) && $stable(f1_v_q))
    else $error("pipeline moved during a stall");

endmodule

// ===== dv/sfpm_checker.sv =====
// Checker of the scan field pixel/mm mapper: mirrors the registers, predicts each result and compares.
module sfpm_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [sfpm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [sfpm_pkg::CMD_W-1:0]      s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [sfpm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [1:0]                      m_axis_tuser,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_o,
  input  logic [2:0]                      cfg_index_i,
  input  logic [sfpm_pkg::CW-1:0]         cfg_data_i,
  output int                              errors_o,
  output int                              pending_o
);
  import sfpm_pkg::*;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 zero;
    logic                 sat;
  } mapped_t;

  longint  x_org, y_org, x_scale, y_scale, slope, img_w, img_h;
  logic [1:0] fill;
  mapped_t mapped_q[$];

  function automatic longint clamp32(input longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic mapped_t map_coord(input cmd_e cmd, input longint a, input longint b,
                                        input longint ww, input longint wh);
    longint  one, xp, xc, yw, xw, mx, my, num, q, rx, ry;
    bit      sat, zero;
    mapped_t r;
    one  = longint'(1) <<< FRAC_BITS;
    rx   = 0;
    ry   = 0;
    xp   = 0;
    yw   = 0;
    sat  = 1'b0;
    zero = 1'b0;
    // Forward transform shared by mm-to-pixel and window corner
    if (cmd == CMD_TO_PIXEL || cmd == CMD_CORNER) begin
      xp = ((a - x_org) * x_scale) >>> FRAC_BITS;
      xc = clamp32(xp, sat);
      yw = (((b - y_org) * y_scale) >>> FRAC_BITS) + ((slope * xc) >>> FRAC_BITS);
    end
    case (cmd)
      CMD_TO_PIXEL: begin
        xw = xp;
        if (fill[0]) xw = img_w * one - one - xw;
        if (fill[1]) yw = img_h * one - one - yw;
        rx = clamp32(xw, sat);
        ry = clamp32(yw, sat);
      end
      CMD_TO_MM: begin
        mx = a;
        my = b;
        if (fill[0]) mx = img_w * one - one - mx;
        if (fill[1]) my = img_h * one - one - my;
        mx = clamp32(mx, sat);
        my = clamp32(my, sat);
        if (x_scale == 0) begin
          zero = 1'b1;
          q    = 0;
        end else begin
          q = (mx * one) / x_scale;
        end
        rx  = clamp32(q + x_org, sat);
        num = clamp32(my - ((slope * mx) >>> FRAC_BITS), sat);
        if (y_scale == 0) begin
          zero = 1'b1;
          q    = 0;
        end else begin
          q = (num * one) / y_scale;
        end
        ry = clamp32(q + y_org, sat);
      end
      CMD_CORNER: begin
        // Division truncates toward zero, as the corner requires
        rx = clamp32(((xp - (ww / 2) * one) / one) * one, sat);
        ry = clamp32(((yw - (wh / 2) * one) / one) * one, sat);
      end
      default: ;
    endcase
    r.x    = rx[CW-1:0];
    r.y    = ry[CW-1:0];
    r.zero = zero;
    r.sat  = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors_o = errors_o + 1;
  endtask

  initial errors_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    mapped_t want;
    mapped_t pred;
    if (!rst_ni) begin
      x_org   = 0;
      y_org   = 0;
      x_scale = longint'(1) <<< FRAC_BITS;
      y_scale = longint'(1) <<< FRAC_BITS;
      slope   = 0;
      img_w   = 0;
      img_h   = 0;
      fill    = '0;
      mapped_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (reg_e'(cfg_index_i))
          REG_X_ORIGIN: x_org   = longint'($signed(cfg_data_i));
          REG_Y_ORIGIN: y_org   = longint'($signed(cfg_data_i));
          REG_X_SCALE:  x_scale = longint'($signed(cfg_data_i));
          REG_Y_SCALE:  y_scale = longint'($signed(cfg_data_i));
          REG_SLOPE:    slope   = longint'($signed(cfg_data_i));
          REG_WIDTH:    img_w   = longint'(cfg_data_i[DIM_W-1:0]);
          REG_HEIGHT:   img_h   = longint'(cfg_data_i[DIM_W-1:0]);
          REG_FILL:     fill    = cfg_data_i[MODE_W-1:0];
          default: ;
        endcase
      end
      // Compare the result transfer with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (mapped_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = mapped_q.pop_front();
          if ($signed(m_axis_tdata[CW-1:0]) != want.x)
            report_mismatch("out_x", $signed(m_axis_tdata[CW-1:0]), want.x);
          if ($signed(m_axis_tdata[2*CW-1:CW]) != want.y)
            report_mismatch("out_y", $signed(m_axis_tdata[2*CW-1:CW]), want.y);
          if (m_axis_tuser[0] != want.zero)
            report_mismatch("scale_zero", m_axis_tuser[0], want.zero);
          if (m_axis_tuser[1] != want.sat)
            report_mismatch("saturated", m_axis_tuser[1], want.sat);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred = map_coord(cmd_e'(s_axis_tuser),
                         longint'($signed(s_axis_tdata[CW-1:0])),
                         longint'($signed(s_axis_tdata[2*CW-1:CW])),
                         longint'(s_axis_tdata[2*CW+DIM_W-1:2*CW]),
                         longint'(s_axis_tdata[2*CW+2*DIM_W-1:2*CW+DIM_W]));
        mapped_q.insert(mapped_q.size(), pred);
      end
    end
    pending_o = mapped_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top of the scan field pixel/mm mapper: clock, reset, stimulus and verdict.
module tb_top;
  import sfpm_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // first_coord, second_coord, window_width, window_height, zero pad
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // cmd
  logic [CMD_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // out_x, out_y
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // scale_zero, saturated
  logic [1:0]            m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [2:0]            cfg_index_i;
  logic [CW-1:0]         cfg_data_i;
  int                    errors;
  int                    pending;

  // Burst bookkeeping of the sender and stall rate of the receiver, in percent
  int burst_left;
  int stall_pct;

  scan_field_pixel_mm_mapper uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  sfpm_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: stall at the rate of the current phase; zero means always ready
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Q16.16 value biased toward the extremes and toward moderate magnitudes
  function automatic logic [CW-1:0] rand_q();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return 32'h0001_0000;
      4, 5:    return CW'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return DIM_W'(1);
      2:       return DIM_W'(10000);
      3:       return '1;
      4:       return DIM_W'($urandom);
      default: return DIM_W'($urandom_range(0, 10000));
    endcase
  endfunction

  // Hold valid within a burst; drop it only for a gap between bursts
  task automatic send_item(input cmd_e cmd, input logic [CW-1:0] a, input logic [CW-1:0] b,
                           input logic [DIM_W-1:0] ww, input logic [DIM_W-1:0] wh);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_DATA_W-2*CW-2*DIM_W){1'b0}}, wh, ww, b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left = burst_left - 1;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted result has left the pipeline
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [CW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_random_item();
    cmd_e cmd;
    cmd = ($urandom_range(0, 19) == 0) ? CMD_UNUSED : cmd_e'($urandom_range(0, 2));
    send_item(cmd, rand_q(), rand_q(), rand_dim(), rand_dim());
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b1;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    burst_left    = 0;
    stall_pct     = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset defaults: unit scales, no mirroring, empty image
    send_item(CMD_TO_PIXEL, '0, '0, '0, '0);
    send_item(CMD_TO_PIXEL, 32'h7fff_ffff, 32'h7fff_ffff, '0, '0);
    send_item(CMD_TO_PIXEL, 32'h8000_0000, 32'h8000_0000, '0, '0);
    send_item(CMD_TO_MM, 32'h8000_0000, 32'h7fff_ffff, '0, '0);
    send_item(CMD_CORNER, 32'h0003_8000, 32'hfffc_8000, '1, '1);
    send_item(CMD_CORNER, 32'h8000_0000, 32'h8000_0000, DIM_W'(10000), DIM_W'(1));
    send_item(CMD_UNUSED, 32'hdead_beef, 32'h1234_5678, '1, '1);
    wait_idle();

    // Zero scales with both mirrors and extreme origins and shear
    write_reg(REG_X_ORIGIN, 32'h8000_0000);
    write_reg(REG_Y_ORIGIN, 32'h7fff_ffff);
    write_reg(REG_X_SCALE, '0);
    write_reg(REG_Y_SCALE, '0);
    write_reg(REG_SLOPE, 32'h7fff_ffff);
    write_reg(REG_WIDTH, 32'd10000);
    write_reg(REG_HEIGHT, 32'd10000);
    write_reg(REG_FILL, 32'd3);
    send_item(CMD_TO_MM, '0, '0, '0, '0);
    send_item(CMD_TO_MM, 32'h7fff_ffff, 32'h8000_0000, '0, '0);
    send_item(CMD_TO_PIXEL, 32'h7fff_ffff, 32'h8000_0000, '0, '0);
    send_item(CMD_CORNER, 32'h7fff_ffff, '0, DIM_W'(10000), DIM_W'(10000));
    wait_idle();

    // Full-scale magnitudes, one mirror at a time
    write_reg(REG_X_SCALE, 32'h8000_0000);
    write_reg(REG_Y_SCALE, 32'h7fff_ffff);
    write_reg(REG_SLOPE, 32'h8000_0000);
    write_reg(REG_FILL, 32'd1);
    send_item(CMD_TO_PIXEL, 32'h7fff_ffff, 32'h8000_0000, '0, '0);
    send_item(CMD_TO_MM, 32'h7fff_ffff, 32'h8000_0000, '0, '0);
    send_item(CMD_CORNER, 32'h8000_0000, 32'h7fff_ffff, '1, '0);
    wait_idle();
    write_reg(REG_FILL, 32'd2);
    send_item(CMD_TO_PIXEL, 32'h0001_0000, 32'hffff_0000, '0, '0);
    send_item(CMD_TO_MM, 32'h0001_0000, 32'hffff_0000, '0, '0);
    send_item(CMD_CORNER, 32'hffff_0001, 32'h0000_ffff, DIM_W'(3), DIM_W'(2));
    wait_idle();

    // Random phases, each with fresh registers and its own stall rate
    for (int phase = 0; phase < 10; phase++) begin
      write_reg(REG_X_ORIGIN, rand_q());
      write_reg(REG_Y_ORIGIN, rand_q());
      write_reg(REG_X_SCALE, rand_q());
      write_reg(REG_Y_SCALE, rand_q());
      write_reg(REG_SLOPE, rand_q());
      write_reg(REG_WIDTH, CW'(rand_dim()));
      write_reg(REG_HEIGHT, CW'(rand_dim()));
      write_reg(REG_FILL, CW'($urandom_range(0, 3)));
      case (phase % 4)
        0:       stall_pct = 0;
        1:       stall_pct = 15;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      repeat (150) send_random_item();
      wait_idle();
    end

    stall_pct = 0;
    repeat (80) @(negedge clk_i);
    if (errors == 0) begin
      $display("scan_field_pixel_mm_mapper test passed");
    end else begin
      $display("scan_field_pixel_mm_mapper test failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20000000;
    $display("scan_field_pixel_mm_mapper test failed");
    $finish;
  end

endmodule
